// ===== rtl/chac_pkg.sv =====
// Shared types, constants and the band decision function for the climate
// actuator hysteresis control core. No dependencies.

package chac_pkg;

  localparam int NUM_ACT = 4;
  localparam int ACT_W   = 2;
  localparam int TEMP_W  = 12;
  localparam int HUM_W   = 10;
  localparam int CO2_W   = 14;
  localparam int LUX_W   = 16;
  localparam int BAND_W  = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  localparam logic [ACT_W-1:0] ACT_FAN    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_HEATER = 2'd1;
  localparam logic [ACT_W-1:0] ACT_HUMID  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_LIGHT  = 2'd3;

  localparam logic signed [BAND_W-1:0] TEMP_HYST = 14'sd5;
  localparam logic signed [BAND_W-1:0] HUM_HYST  = 14'sd20;
  localparam logic [CO2_W:0]           CO2_BAND  = 15'd100;
  localparam logic [LUX_W-1:0]         LUX_DARK  = 16'd50;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN_RST = 12'sd230;
  localparam logic signed [TEMP_W-1:0] TEMP_OPT_RST = 12'sd255;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX_RST = 12'sd280;
  localparam logic [HUM_W-1:0]         HUM_MIN_RST  = 10'd700;
  localparam logic [HUM_W-1:0]         HUM_OPT_RST  = 10'd775;
  localparam logic [HUM_W-1:0]         HUM_MAX_RST  = 10'd850;
  localparam logic [CO2_W-1:0]         CO2_OPT_RST  = 14'd500;
  localparam logic [CO2_W-1:0]         CO2_MAX_RST  = 14'd1000;

  typedef enum logic [1:0] {
    REQ_SENSOR = 2'd0,
    REQ_MODE   = 2'd1,
    REQ_MANUAL = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_MIN = 3'd0,
    CFG_TEMP_OPT = 3'd1,
    CFG_TEMP_MAX = 3'd2,
    CFG_HUM_MIN  = 3'd3,
    CFG_HUM_OPT  = 3'd4,
    CFG_HUM_MAX  = 3'd5,
    CFG_CO2_OPT  = 3'd6,
    CFG_CO2_MAX  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_min;
    logic signed [TEMP_W-1:0] temp_opt;
    logic signed [TEMP_W-1:0] temp_max;
    logic [HUM_W-1:0]         hum_min;
    logic [HUM_W-1:0]         hum_opt;
    logic [HUM_W-1:0]         hum_max;
    logic [CO2_W-1:0]         co2_opt;
    logic [CO2_W-1:0]         co2_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [ACT_W-1:0]         actuator;
    logic                     command_value;
    logic signed [TEMP_W-1:0] temp_tenths;
    logic                     temp_valid;
    logic [HUM_W-1:0]         hum_tenths;
    logic                     hum_valid;
    logic [CO2_W-1:0]         co2_ppm;
    logic [LUX_W-1:0]         lux_level;
    logic                     lux_valid;
  } in_item_t;

  typedef struct packed {
    logic [NUM_ACT-1:0] old_st;
    logic [NUM_ACT-1:0] new_st;
    logic               by_auto;
  } ev_t;

  function automatic logic band_on(
    input logic                     was_on,
    input logic signed [BAND_W-1:0] x,
    input logic signed [BAND_W-1:0] lo,
    input logic signed [BAND_W-1:0] opt,
    input logic signed [BAND_W-1:0] hi,
    input logic signed [BAND_W-1:0] hyst
  );
    logic res;
    if (x < lo) begin
      res = 1'b1;
    end else if (x > hi) begin
      res = 1'b0;
    end else if (!was_on && (x < opt - hyst)) begin
      res = 1'b1;
    end else if (was_on && (x > opt + hyst)) begin
      res = 1'b0;
    end else begin
      res = was_on;
    end
    return res;
  endfunction

endpackage

// ===== rtl/climate_actuator_hysteresis_control.sv =====
// Top level of the climate actuator hysteresis control core.
// Depends on chac_pkg, chac_cfg, chac_ctrl and chac_emit.

module climate_actuator_hysteresis_control_core
  import chac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write: cfg_index selects the threshold, cfg_data low bits hold it.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // in_tdata from bit 0: actuator[1:0], command_value[2], temp_tenths[14:3],
  // temp_valid[15], hum_tenths[25:16], hum_valid[26], co2_ppm[40:27],
  // lux_level[56:41], lux_valid[57], zero[63:58].
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: req_type[1:0].
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata from bit 0: which_actuator[1:0], switched_on[2], by_auto[3],
  // all_states[7:4].
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  // Each input transaction enters a decision register and is evaluated there
  // combinationally against the actuator and mode state. An input causes zero
  // to four output transactions (fan, heater, humidifier, light order), which
  // leave the event register one per cycle while the output is ready. The first
  // result is presented once the input has passed the decision register and
  // then the event register. While an input that causes more than one change
  // drains, further input is held back, so a transaction per cycle is sustained
  // only while each input causes at most one change and the output is ready.
  // Output stalls hold back the input as well. No clearing pass follows reset.
  // Configuration writes are always accepted and take effect on the next cycle.

  cfg_t     cfg;
  in_item_t item;
  ev_t      ev;
  logic     ev_valid;
  logic     ev_ready;

  assign cfg_ready = 1'b1;

  always_comb begin
    item.req_type      = in_tuser;
    item.actuator      = in_tdata[1:0];
    item.command_value = in_tdata[2];
    item.temp_tenths   = $signed(in_tdata[14:3]);
    item.temp_valid    = in_tdata[15];
    item.hum_tenths    = in_tdata[25:16];
    item.hum_valid     = in_tdata[26];
    item.co2_ppm       = in_tdata[40:27];
    item.lux_level     = in_tdata[56:41];
    item.lux_valid     = in_tdata[57];
  end

  chac_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  chac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .ev_valid   (ev_valid),
    .ev_ready   (ev_ready),
    .ev         (ev)
  );

  chac_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_valid   (ev_valid),
    .ev_ready   (ev_ready),
    .ev         (ev),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/chac_cfg.sv =====
// Threshold register file written through the configuration channel.
// Depends on chac_pkg.

module chac_cfg
  import chac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_TEMP_MIN: cfg_nxt.temp_min = $signed(wr_data[TEMP_W-1:0]);
        CFG_TEMP_OPT: cfg_nxt.temp_opt = $signed(wr_data[TEMP_W-1:0]);
        CFG_TEMP_MAX: cfg_nxt.temp_max = $signed(wr_data[TEMP_W-1:0]);
        CFG_HUM_MIN:  cfg_nxt.hum_min  = wr_data[HUM_W-1:0];
        CFG_HUM_OPT:  cfg_nxt.hum_opt  = wr_data[HUM_W-1:0];
        CFG_HUM_MAX:  cfg_nxt.hum_max  = wr_data[HUM_W-1:0];
        CFG_CO2_OPT:  cfg_nxt.co2_opt  = wr_data[CO2_W-1:0];
        CFG_CO2_MAX:  cfg_nxt.co2_max  = wr_data[CO2_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_min <= TEMP_MIN_RST;
      cfg_r.temp_opt <= TEMP_OPT_RST;
      cfg_r.temp_max <= TEMP_MAX_RST;
      cfg_r.hum_min  <= HUM_MIN_RST;
      cfg_r.hum_opt  <= HUM_OPT_RST;
      cfg_r.hum_max  <= HUM_MAX_RST;
      cfg_r.co2_opt  <= CO2_OPT_RST;
      cfg_r.co2_max  <= CO2_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/chac_ctrl.sv =====
// Input register, actuator and mode state, and the on/off decision logic.
// Hands one event record per transaction to the emitter. Depends on chac_pkg.

module chac_ctrl
  import chac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     item_valid,
  output logic     item_ready,
  input  in_item_t item,
  output logic     ev_valid,
  input  logic     ev_ready,
  output ev_t      ev
);

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  in_item_t           s1_item_r;
  logic [NUM_ACT-1:0] act_on_r;
  logic [NUM_ACT-1:0] act_on_nxt;
  logic [NUM_ACT-1:0] auto_mode_r;
  logic [NUM_ACT-1:0] auto_mode_nxt;
  logic               commit;
  logic [NUM_ACT-1:0] need;
  logic [NUM_ACT-1:0] new_st;
  logic               fan_co2;
  logic               fan_temp;
  logic               fan_hum;
  logic signed [BAND_W-1:0] temp_x;
  logic signed [BAND_W-1:0] tmin_x;
  logic signed [BAND_W-1:0] topt_x;
  logic signed [BAND_W-1:0] tmax_x;
  logic signed [BAND_W-1:0] hum_x;
  logic signed [BAND_W-1:0] hmin_x;
  logic signed [BAND_W-1:0] hopt_x;
  logic signed [BAND_W-1:0] hmax_x;

  assign item_ready = !s1_valid_r || ev_ready;
  assign commit     = s1_valid_r && ev_ready;
  assign ev_valid   = s1_valid_r;

  always_comb begin
    temp_x = $signed({{(BAND_W-TEMP_W){s1_item_r.temp_tenths[TEMP_W-1]}},
                      s1_item_r.temp_tenths});
    tmin_x = $signed({{(BAND_W-TEMP_W){cfg.temp_min[TEMP_W-1]}}, cfg.temp_min});
    topt_x = $signed({{(BAND_W-TEMP_W){cfg.temp_opt[TEMP_W-1]}}, cfg.temp_opt});
    tmax_x = $signed({{(BAND_W-TEMP_W){cfg.temp_max[TEMP_W-1]}}, cfg.temp_max});
    hum_x  = $signed({{(BAND_W-HUM_W){1'b0}}, s1_item_r.hum_tenths});
    hmin_x = $signed({{(BAND_W-HUM_W){1'b0}}, cfg.hum_min});
    hopt_x = $signed({{(BAND_W-HUM_W){1'b0}}, cfg.hum_opt});
    hmax_x = $signed({{(BAND_W-HUM_W){1'b0}}, cfg.hum_max});

    fan_co2  = (s1_item_r.co2_ppm != '0) &&
               ((s1_item_r.co2_ppm > cfg.co2_max) ||
                ({1'b0, s1_item_r.co2_ppm} > ({1'b0, cfg.co2_opt} + CO2_BAND)));
    fan_temp = s1_item_r.temp_valid &&
               ((temp_x > tmax_x) || (temp_x > topt_x + TEMP_HYST));
    fan_hum  = s1_item_r.hum_valid &&
               ((hum_x > hmax_x) || (hum_x > hopt_x + HUM_HYST));

    need[ACT_FAN]    = fan_co2 || fan_temp || fan_hum;
    need[ACT_HEATER] = s1_item_r.temp_valid &&
                       band_on(act_on_r[ACT_HEATER], temp_x, tmin_x, topt_x, tmax_x,
                               TEMP_HYST);
    need[ACT_HUMID]  = s1_item_r.hum_valid &&
                       band_on(act_on_r[ACT_HUMID], hum_x, hmin_x, hopt_x, hmax_x,
                               HUM_HYST);
    need[ACT_LIGHT]  = s1_item_r.lux_valid && (s1_item_r.lux_level < LUX_DARK);
  end

  always_comb begin
    new_st        = act_on_r;
    auto_mode_nxt = auto_mode_r;
    unique case (s1_item_r.req_type)
      REQ_SENSOR: begin
        new_st = (need & auto_mode_r) | (act_on_r & ~auto_mode_r);
      end
      REQ_MODE: begin
        auto_mode_nxt[s1_item_r.actuator] = s1_item_r.command_value;
      end
      REQ_MANUAL: begin
        if (!auto_mode_r[s1_item_r.actuator]) begin
          new_st[s1_item_r.actuator] = s1_item_r.command_value;
        end
      end
      default: begin
        new_st = act_on_r;
      end
    endcase
    if (!commit) begin
      auto_mode_nxt = auto_mode_r;
    end
    act_on_nxt = commit ? new_st : act_on_r;
  end

  assign ev.old_st  = act_on_r;
  assign ev.new_st  = new_st;
  assign ev.by_auto = (s1_item_r.req_type == REQ_SENSOR);

  assign s1_valid_nxt = item_ready ? item_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      act_on_r    <= '0;
      auto_mode_r <= '1;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      act_on_r    <= act_on_nxt;
      auto_mode_r <= auto_mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item_r <= item;
    end
  end

  a_manual_single_change: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_valid && !ev.by_auto) |-> $onehot0(ev.old_st ^ ev.new_st))
    else $error("manual or mode transaction changes more than one actuator");

  a_auto_respects_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_valid && ev.by_auto) |-> (((ev.old_st ^ ev.new_st) & ~auto_mode_r) == '0))
    else $error("automatic control changed an actuator in manual mode");

  a_commit_updates_state: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (act_on_r == $past(new_st)))
    else $error("actuator state does not follow committed decision");

endmodule

// ===== rtl/chac_emit.sv =====
// Event register that drains the actuator changes of one transaction, lowest
// actuator first, one output per cycle while out_tready. Depends on chac_pkg.

module chac_emit
  import chac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ev_valid,
  output logic                  ev_ready,
  input  ev_t                   ev,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic [NUM_ACT-1:0] pend_r;
  logic [NUM_ACT-1:0] pend_nxt;
  logic [NUM_ACT-1:0] old_r;
  logic [NUM_ACT-1:0] new_r;
  logic               by_auto_r;
  logic [ACT_W-1:0]   idx;
  logic [NUM_ACT-1:0] le_mask;
  logic [NUM_ACT-1:0] all_states;
  logic               single;
  logic               load;
  logic               take;

  always_comb begin
    idx = '0;
    for (int i = NUM_ACT - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        idx = ACT_W'(i);
      end
    end
    for (int j = 0; j < NUM_ACT; j++) begin
      le_mask[j] = (ACT_W'(j) <= idx);
    end
  end

  assign single     = (pend_r != '0) && ((pend_r & (pend_r - NUM_ACT'(1))) == '0);
  assign all_states = (new_r & le_mask) | (old_r & ~le_mask);
  assign out_tvalid = (pend_r != '0);
  assign take       = out_tvalid && out_tready;
  assign ev_ready   = (pend_r == '0) || (out_tready && single);
  assign load       = ev_valid && ev_ready;
  assign out_tdata  = {all_states, by_auto_r, new_r[idx], idx};
  assign out_tlast  = single;

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt = ev.old_st ^ ev.new_st;
    end else if (take) begin
      pend_nxt = pend_r & ~(NUM_ACT'(1) << idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      old_r     <= ev.old_st;
      new_r     <= ev.new_st;
      by_auto_r <= ev.by_auto;
    end
  end

  a_drain_one_per_transaction: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !load) |=> ($countones(pend_r) == $past($countones(pend_r)) - 1))
    else $error("pending change count did not drop by one");

endmodule
